// ===== design/dc_ltk_pkg.sv =====
// Shared types, constants and character functions for the lock-to-key block.
// No dependencies; used by dc_ltk_front, dc_ltk_emit and dc_lock_to_key_top.
`default_nettype none
package dc_ltk_pkg;

	localparam int MAX_LOCK_LEN = 1024;
	localparam int POS_CAP_I = ((MAX_LOCK_LEN - 1) < 1023) ? (MAX_LOCK_LEN - 1) : 1023;
	localparam logic [9:0] POS_CAP = 10'(POS_CAP_I);

	localparam logic [3:0] LAST_CHR = 4'd9;   // ten-character texts end here
	localparam logic [7:0] KEY_SALT = 8'd5;

	// One accepted lock byte turns into up to three key bytes, or the fallback text.
	typedef struct packed {
		logic             fb;
		logic             lock_last;
		logic [1:0]       nkeys;
		logic [2:0][7:0]  keys;
		logic [2:0][9:0]  pos;
	} ltk_job_t;

	function automatic logic [7:0] nib_swap(input logic [7:0] v);
		return {v[3:0], v[7:4]};
	endfunction

	function automatic logic is_esc(input logic [7:0] k);
		return (k == 8'd0) || (k == 8'd5) || (k == 8'd36) || (k == 8'd96) ||
			(k == 8'd124) || (k == 8'd126);
	endfunction

	// Character c of "/%DCNnnn%/" for an escaped key byte.
	function automatic logic [7:0] esc_char(input logic [7:0] k, input logic [3:0] c);
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
		logic [7:0] ch;
		d2 = 4'd0;
		d1 = 4'd0;
		d0 = 4'd0;
		case (k)
			8'd5:    begin d0 = 4'd5; end
			8'd36:   begin d1 = 4'd3; d0 = 4'd6; end
			8'd96:   begin d1 = 4'd9; d0 = 4'd6; end
			8'd124:  begin d2 = 4'd1; d1 = 4'd2; d0 = 4'd4; end
			8'd126:  begin d2 = 4'd1; d1 = 4'd2; d0 = 4'd6; end
			default: begin d0 = 4'd0; end
		endcase
		case (c)
			4'd0:    ch = "/";
			4'd1:    ch = "%";
			4'd2:    ch = "D";
			4'd3:    ch = "C";
			4'd4:    ch = "N";
			4'd5:    ch = 8'("0") + {4'd0, d2};
			4'd6:    ch = 8'("0") + {4'd0, d1};
			4'd7:    ch = 8'("0") + {4'd0, d0};
			4'd8:    ch = "%";
			default: ch = "/";
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] fallback_char(input logic [3:0] c);
		logic [7:0] ch;
		case (c)
			4'd0:    ch = "S";
			4'd1:    ch = "T";
			4'd2:    ch = "U";
			4'd3:    ch = "P";
			4'd4:    ch = "I";
			4'd5:    ch = "D";
			4'd6:    ch = "K";
			4'd7:    ch = "E";
			4'd8:    ch = "Y";
			default: ch = "!";
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== design/dc_ltk_front.sv =====
// Input side: lock state registers and the per-byte job register.
// Depends on dc_ltk_pkg.
`default_nettype none
module dc_ltk_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               lock_valid,
	output logic                    lock_ready,
	input  wire logic [7:0]         lock_byte,
	input  wire logic               lock_end,
	input  wire logic               pop,
	output logic                    job_valid_s1,
	output dc_ltk_pkg::ltk_job_t    job_s1
);

	logic [7:0] first_q;
	logic [7:0] prev_q;
	logic [7:0] held_q;
	logic [9:0] count_q;
	logic       accept;
	logic [7:0] ks;
	logic [7:0] k0;
	logic       past_two;
	dc_ltk_pkg::ltk_job_t job_d;

	assign lock_ready = !job_valid_s1 || pop;
	assign accept     = lock_valid && lock_ready;
	assign ks         = dc_ltk_pkg::nib_swap(lock_byte ^ prev_q);
	assign k0         = dc_ltk_pkg::nib_swap(first_q ^ lock_byte ^ prev_q ^ dc_ltk_pkg::KEY_SALT);
	assign past_two   = count_q >= 10'd2;

	always_comb begin
		job_d           = '0;
		job_d.lock_last = lock_end;
		if (count_q == 10'd2) begin
			job_d.keys[0] = held_q;
			job_d.pos[0]  = 10'd1;
			job_d.keys[1] = ks;
			job_d.pos[1]  = 10'd2;
			job_d.nkeys   = 2'd2;
			if (lock_end) begin
				job_d.keys[2] = k0;
				job_d.nkeys   = 2'd3;
			end
		end else if (past_two) begin
			job_d.keys[0] = ks;
			job_d.pos[0]  = count_q;
			job_d.nkeys   = 2'd1;
			if (lock_end) begin
				job_d.keys[1] = k0;
				job_d.nkeys   = 2'd2;
			end
		end else if (lock_end) begin
			job_d.fb = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			prev_q       <= '0;
			held_q       <= '0;
			count_q      <= '0;
			job_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (count_q == 10'd0) first_q <= lock_byte;
				if (count_q == 10'd1) held_q <= ks;
				if (lock_end) begin
					count_q <= '0;
				end else if (count_q < dc_ltk_pkg::POS_CAP) begin
					count_q <= count_q + 10'd1;
				end
				prev_q       <= lock_byte;
				job_valid_s1 <= job_d.fb || (job_d.nkeys != 2'd0);
			end else if (pop) begin
				job_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) job_s1 <= job_d;
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dc_ltk_pkg::POS_CAP)
		else $error("byte count past cap");
	a_hold_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 && !pop && !accept |=> job_valid_s1)
		else $error("job dropped before emission");

endmodule
`default_nettype wire

// ===== design/dc_ltk_emit.sv =====
// Output side: walks the held job character by character into the result register.
// Depends on dc_ltk_pkg.
`default_nettype none
module dc_ltk_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid_s1,
	input  wire dc_ltk_pkg::ltk_job_t job_s1,
	output logic                    pop,
	output logic                    key_valid,
	input  wire logic               key_ready,
	output logic [7:0]              key_char,
	output logic [9:0]              key_pos,
	output logic                    fallback,
	output logic                    run_last,
	output logic                    key_done
);

	logic [1:0] slot_q;
	logic [3:0] chr_q;
	logic       load;
	logic [7:0] cur_key;
	logic       cur_esc;
	logic       chr_last;
	logic       job_last;
	logic [7:0] char_d;
	logic [9:0] pos_d;

	assign load     = job_valid_s1 && (!key_valid || key_ready);
	assign cur_key  = job_s1.keys[slot_q];
	assign cur_esc  = dc_ltk_pkg::is_esc(cur_key);
	assign chr_last = (job_s1.fb || cur_esc) ? (chr_q == dc_ltk_pkg::LAST_CHR) : 1'b1;
	assign job_last = chr_last && (job_s1.fb || (slot_q == (job_s1.nkeys - 2'd1)));
	assign pop      = load && job_last;

	always_comb begin
		if (job_s1.fb) begin
			char_d = dc_ltk_pkg::fallback_char(chr_q);
			pos_d  = '0;
		end else begin
			char_d = cur_esc ? dc_ltk_pkg::esc_char(cur_key, chr_q) : cur_key;
			pos_d  = job_s1.pos[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			chr_q     <= '0;
			key_valid <= 1'b0;
		end else begin
			if (load) begin
				key_valid <= 1'b1;
				if (job_last) begin
					slot_q <= '0;
					chr_q  <= '0;
				end else if (chr_last) begin
					slot_q <= slot_q + 2'd1;
					chr_q  <= '0;
				end else begin
					chr_q <= chr_q + 4'd1;
				end
			end else if (key_ready) begin
				key_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_char <= char_d;
			key_pos  <= pos_d;
			fallback <= job_s1.fb;
			run_last <= job_last;
			key_done <= job_last && job_s1.lock_last;
		end
	end

	a_chr_range: assert property (@(posedge clk) disable iff (!arst_n)
		chr_q <= dc_ltk_pkg::LAST_CHR)
		else $error("character index out of range");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_done |-> run_last)
		else $error("key end without run end");
	a_fb_pos: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && fallback |-> key_pos == 10'd0)
		else $error("fallback text with nonzero position");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> slot_q == 2'd0 && chr_q == 4'd0)
		else $error("counters not rewound after job");

endmodule
`default_nettype wire

// ===== design/dc_lock_to_key_top.sv =====
// Top level of the lock-to-key transformer.
// Depends on dc_ltk_pkg, dc_ltk_front and dc_ltk_emit.
//
// Usage:
//   Lock channel (lock_valid/lock_ready, lock_byte, lock_end) takes one lock
//   byte per word; lock_end marks the final byte of a lock, and the next word
//   starts a new lock. Key channel (key_valid/key_ready) gives one key text
//   character per word with its key position, the fallback flag, run_last on
//   the last character caused by an input word and key_done on the last
//   character of the whole key. Key byte 0 comes last, tagged position 0.
//   Escaped key bytes (0, 5, 36, 96, 124, 126) become the ten characters
//   /%DCNnnn%/; a lock of fewer than three bytes yields STUPIDKEY!.
// Path: an accepted word is written to the job register; its characters then
//   move from there into the result register.
// Throughput: one character per cycle while key_ready is high. A word that
//   makes one character or none is then taken every cycle; a word that makes
//   more holds the job register until its last character is loaded (up to 30
//   characters for a final byte whose three key bytes are all escaped).
// Reset: arst_n clears the lock state, the count and both valid flags at once.
// Stall: with key_valid high and key_ready low the result register holds; the job register
//   waits behind it and lock_ready drops once a job is pending.
`default_nettype none
module dc_lock_to_key_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        lock_valid,
	output logic             lock_ready,
	input  wire logic [7:0]  lock_byte,
	input  wire logic        lock_end,
	output logic             key_valid,
	input  wire logic        key_ready,
	output logic [7:0]       key_char,
	output logic [9:0]       key_pos,
	output logic             fallback,
	output logic             run_last,
	output logic             key_done
);

	logic                  pop;
	logic                  job_valid_s1;
	dc_ltk_pkg::ltk_job_t  job_s1;

	// Build at most one job per lock word and hold the running lock state.
	dc_ltk_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.lock_valid   (lock_valid),
		.lock_ready   (lock_ready),
		.lock_byte    (lock_byte),
		.lock_end     (lock_end),
		.pop          (pop),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1)
	);

	// Emit the job into the result register, one character per unstalled cycle.
	dc_ltk_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid_s1 (job_valid_s1),
		.job_s1       (job_s1),
		.pop          (pop),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.key_char     (key_char),
		.key_pos      (key_pos),
		.fallback     (fallback),
		.run_last     (run_last),
		.key_done     (key_done)
	);

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for dc_lock_to_key_top: lock bytes go in, key text characters come out.
// Depends on dc_ltk_pkg (POS_CAP) and the design sources; expected key text is predicted here.
module testbench;

	localparam int HALF_PERIOD  = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 250;
	localparam int MAX_REPORTS  = 10;

	localparam logic [7:0]  LOCK_SALT       = 8'h05;
	localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
	localparam logic [79:0] SHORT_LOCK_TEXT = "STUPIDKEY!";
	localparam logic [39:0] ESC_HEAD        = "/%DCN";
	localparam logic [15:0] ESC_TAIL        = "%/";
	localparam logic [7:0]  ESC_KEYS [6]    = '{8'd0, 8'd5, 8'd36, 8'd96, 8'd124, 8'd126};

	// One character of key text as it leaves the key channel.
	typedef struct packed {
		logic [7:0] ch;
		logic [9:0] pos;
		logic       fb;
		logic       rl;
		logic       dn;
	} key_word_t;

	// One row of the directed script. Typed rows carry their key text in the row
	// (nothing, or the short-lock text); the others are left to the predictor.
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        typed;
		logic [3:0]  text_len;
		logic [79:0] text;
	} script_row_t;

	localparam int N_SCRIPT = 20;
	localparam script_row_t LOCK_SCRIPT [N_SCRIPT] = '{
		// one-byte lock right after reset, zero byte value: short-lock text
		'{8'h00, 1'b1, 1'b1, 4'd10, SHORT_LOCK_TEXT},
		// two-byte lock: first byte is held, the second ends it, held key byte 1 is dropped
		'{8'hFF, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h00, 1'b1, 1'b1, 4'd10, SHORT_LOCK_TEXT},
		// three-byte lock where key bytes 1, 2 and 0 all escape: thirty characters
		'{8'h05, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h05, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h05, 1'b1, 1'b0, 4'd0,  80'd0},
		// extreme byte values, plain key bytes
		'{8'hFF, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h00, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'hFF, 1'b1, 1'b0, 4'd0,  80'd0},
		// walk every escaped key value: 0, 5, 36, 96, 124, 126
		'{8'h00, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h00, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h50, 1'b0, 1'b0, 4'd0,  80'd0},
		'{8'h12, 1'b0, 1'b0, 4'd0,  80'd0},
		'{8'h14, 1'b0, 1'b0, 4'd0,  80'd0},
		'{8'hD3, 1'b0, 1'b0, 4'd0,  80'd0},
		'{8'h34, 1'b1, 1'b0, 4'd0,  80'd0},
		// four-byte lock with single-bit-set and single-bit-clear patterns
		'{8'h80, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h7F, 1'b0, 1'b1, 4'd0,  80'd0},
		'{8'h01, 1'b0, 1'b0, 4'd0,  80'd0},
		'{8'hFE, 1'b1, 1'b0, 4'd0,  80'd0}
	};

	// Drive every input from time zero; only nonblocking writes follow.
	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       lock_valid = 1'b0;
	logic [7:0] lock_byte  = 8'd0;
	logic       lock_end   = 1'b0;
	logic       key_ready  = 1'b0;
	logic       lock_ready;
	logic       key_valid;
	logic [7:0] key_char;
	logic [9:0] key_pos;
	logic       fallback;
	logic       run_last;
	logic       key_done;

	dc_lock_to_key_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.lock_valid (lock_valid),
		.lock_ready (lock_ready),
		.lock_byte  (lock_byte),
		.lock_end   (lock_end),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_char   (key_char),
		.key_pos    (key_pos),
		.fallback   (fallback),
		.run_last   (run_last),
		.key_done   (key_done)
	);

	always #HALF_PERIOD clk = ~clk;

	// Predictor state: a private copy of the lock tracking.
	logic [7:0] lk_first     = 8'd0;
	logic [7:0] lk_prev      = 8'd0;
	logic [7:0] key_one_held = 8'd0;
	logic [9:0] lk_count     = 10'd0;

	key_word_t run_words [$];      // key text caused by the word just accepted
	key_word_t key_words_due [$];  // key text still to come out, oldest first

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked    = 0;
	int hold_given    = 0;
	int hold_left     = 0;
	int mismatches    = 0;
	int cycle_count   = 0;

	function automatic logic [7:0] nibble_flip(input logic [7:0] v);
		return {v[3:0], v[7:4]};
	endfunction

	function automatic logic needs_escape(input logic [7:0] k);
		logic hit;
		hit = 1'b0;
		foreach (ESC_KEYS[i])
			if (ESC_KEYS[i] == k)
				hit = 1'b1;
		return hit;
	endfunction

	function automatic logic [7:0] pick_escape();
		return ESC_KEYS[$urandom_range(5)];
	endfunction

	function automatic void put_text_char(input logic [7:0] ch, input logic [9:0] pos,
		input logic fb);
		key_word_t w;
		w = '{ch: ch, pos: pos, fb: fb, rl: 1'b0, dn: 1'b0};
		run_words.push_back(w);
	endfunction

	// Escaped key bytes expand to /%DCNnnn%/, all others go out as themselves.
	function automatic void put_key_byte(input logic [7:0] k, input logic [9:0] pos);
		if (needs_escape(k)) begin
			for (int i = 0; i < 5; i++)
				put_text_char(ESC_HEAD[39 - 8*i -: 8], pos, 1'b0);
			put_text_char(DIGIT_ZERO + 8'(k / 100), pos, 1'b0);
			put_text_char(DIGIT_ZERO + 8'((k / 10) % 10), pos, 1'b0);
			put_text_char(DIGIT_ZERO + 8'(k % 10), pos, 1'b0);
			put_text_char(ESC_TAIL[15:8], pos, 1'b0);
			put_text_char(ESC_TAIL[7:0], pos, 1'b0);
		end else begin
			put_text_char(k, pos, 1'b0);
		end
	endfunction

	// Tag the last character of the run, and the end of the key on a final byte.
	function automatic void close_run(input logic last);
		if (run_words.size() != 0) begin
			run_words[run_words.size() - 1].rl = 1'b1;
			run_words[run_words.size() - 1].dn = last;
		end
	endfunction

	// Work out the key text that one accepted lock byte causes.
	function automatic void predict_lock_byte(input logic [7:0] data, input logic last);
		logic [9:0] idx;
		idx = lk_count;
		run_words.delete();
		if (idx == 10'd0) begin
			lk_first = data;
		end else if (idx == 10'd1) begin
			key_one_held = nibble_flip(data ^ lk_prev);
		end else if (idx == 10'd2) begin
			put_key_byte(key_one_held, 10'd1);
			put_key_byte(nibble_flip(data ^ lk_prev), 10'd2);
		end else begin
			put_key_byte(nibble_flip(data ^ lk_prev), idx);
		end
		if (last) begin
			if (idx < 10'd2) begin
				for (int i = 0; i < 10; i++)
					put_text_char(SHORT_LOCK_TEXT[79 - 8*i -: 8], 10'd0, 1'b1);
			end else begin
				put_key_byte(nibble_flip(lk_first ^ data ^ lk_prev ^ LOCK_SALT), 10'd0);
			end
			lk_count = 10'd0;
		end else if (lk_count < dc_ltk_pkg::POS_CAP) begin
			lk_count = lk_count + 10'd1;
		end
		lk_prev = data;
		close_run(last);
	endfunction

	// Offer one lock word, idling at random first; hold it until accepted.
	task automatic send_word(input logic [7:0] data, input logic last, input logic typed,
		input logic [3:0] text_len, input logic [79:0] text);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			lock_valid <= 1'b0;
			@(negedge clk);
		end
		lock_valid <= 1'b1;
		lock_byte  <= data;
		lock_end   <= last;
		@(posedge clk);
		while (!lock_ready)
			@(posedge clk);
		predict_lock_byte(data, last);
		// Rows with typed key text replace the predicted run; state still advances.
		if (typed) begin
			run_words.delete();
			for (int i = 0; i < text_len; i++)
				put_text_char(text[79 - 8*i -: 8], 10'd0, 1'b1);
			close_run(last);
		end
		foreach (run_words[i])
			key_words_due.push_back(run_words[i]);
	endtask

	// Send one well-formed lock with random content. Some bytes are steered so that
	// key bytes escape, including key byte 0 on the final byte.
	task automatic send_random_lock(input int n_bytes);
		logic [7:0] data;
		logic [7:0] head;
		logic [7:0] prior;
		head  = 8'd0;
		prior = 8'd0;
		for (int j = 0; j < n_bytes; j++) begin
			data = 8'($urandom);
			if (j == n_bytes - 1 && j >= 2 && $urandom_range(3) == 0)
				data = head ^ prior ^ LOCK_SALT ^ nibble_flip(pick_escape());
			else if (j > 0 && $urandom_range(3) == 0)
				data = prior ^ nibble_flip(pick_escape());
			if (j == 0)
				head = data;
			send_word(data, j == n_bytes - 1, 1'b0, 4'd0, 80'd0);
			prior = data;
		end
	endtask

	// Random locks, mostly of normal length, some short ones that fall back.
	task automatic run_phase(input int n_words, input int snd_pct, input int rcv_pct);
		int sent;
		int len;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(7) == 0)
				len = int'($urandom_range(2, 1));
			else
				len = int'($urandom_range(12, 3));
			send_random_lock(len);
			sent += len;
		end
	endtask

	// Key side: idle at random, or hold ready low for a long stretch on request.
	always @(negedge clk) begin
		if (hold_asked != hold_given) begin
			hold_given <= hold_asked;
			hold_left  <= HOLD_CYCLES;
			key_ready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			key_ready <= 1'b0;
		end else begin
			key_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each accepted key word against the oldest expected one.
	always @(posedge clk) begin : check_key
		key_word_t want;
		key_word_t got;
		if (arst_n && key_valid && key_ready) begin
			got = '{ch: key_char, pos: key_pos, fb: fallback, rl: run_last, dn: key_done};
			if (key_words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected key word char %h pos %0d fb %b last %b done %b",
						$realtime, got.ch, got.pos, got.fb, got.rl, got.dn);
			end else begin
				want = key_words_due.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: want %h/%0d/%b%b%b got %h/%0d/%b%b%b",
							$realtime, want.ch, want.pos, want.fb, want.rl, want.dn,
							got.ch, got.pos, got.fb, got.rl, got.dn);
				end
			end
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed script under the first idling mix.
		send_idle_pct = 37;
		recv_idle_pct = 47;
		foreach (LOCK_SCRIPT[r])
			send_word(LOCK_SCRIPT[r].data, LOCK_SCRIPT[r].last, LOCK_SCRIPT[r].typed,
				LOCK_SCRIPT[r].text_len, LOCK_SCRIPT[r].text);

		run_phase(65, 37, 47);
		run_phase(65, 47, 37);

		// Hold off the key side while locks keep coming, so the block backs up and
		// drops lock_ready; then run without idling.
		hold_asked++;
		run_phase(60, 0, 0);

		@(negedge clk);
		lock_valid <= 1'b0;

		while (key_words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/dc_ltk_pkg.sv
design/dc_ltk_front.sv
design/dc_ltk_emit.sv
design/dc_lock_to_key_top.sv
tb/testbench.sv
